### src/kvst_pkg.sv
`timescale 1ns / 1ps

package kvst_pkg;

  // Parser state codes
  localparam logic [2:0] ST_WS         = 3'd0;
  localparam logic [2:0] ST_COMMENT    = 3'd1;
  localparam logic [2:0] ST_KEY        = 3'd2;
  localparam logic [2:0] ST_AFTER_KEY  = 3'd3;
  localparam logic [2:0] ST_BEFORE_VAL = 3'd4;
  localparam logic [2:0] ST_VAL        = 3'd5;
  localparam logic [2:0] ST_AFTER_VAL  = 3'd6;

  // Event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_KEY  = 2'd1;
  localparam logic [1:0] EV_VAL  = 2'd2;
  localparam logic [1:0] EV_DONE = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR     = 3'd1;
  localparam logic [2:0] ERR_KEY_NEWLINE  = 3'd2;
  localparam logic [2:0] ERR_AFTER_KEY    = 3'd3;
  localparam logic [2:0] ERR_BEFORE_VALUE = 3'd4;
  localparam logic [2:0] ERR_VAL_NEWLINE  = 3'd5;
  localparam logic [2:0] ERR_AFTER_VALUE  = 3'd6;

  // Special characters
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic [2:0] parser_state;
    logic       match_index;
  } kvst_state_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
  } kvst_result_t;

endpackage

### src/kvst_step.sv
`timescale 1ns / 1ps

module kvst_step (
  input  kvst_pkg::kvst_state_t  state_i,
  input  logic [7:0]             in_byte_i,
  input  logic                   first_byte_i,
  output kvst_pkg::kvst_state_t  state_o,
  output kvst_pkg::kvst_result_t result_o
);
  import kvst_pkg::*;

  kvst_state_t cur;
  logic        is_ws;

  // Restart at whitespace on the first byte of a file
  always_comb begin
    cur = state_i;
    if (first_byte_i) begin
      cur.parser_state = ST_WS;
      cur.match_index  = 1'b0;
    end
  end

  // C-locale whitespace: space, tab, LF, VT, FF, CR
  assign is_ws = in_byte_i inside {8'h20, [8'h09:8'h0D]};

  // Advance the parser by one byte
  always_comb begin
    state_o             = cur;
    state_o.match_index = 1'b0;
    result_o.event_kind = EV_NONE;
    result_o.out_byte   = 8'h00;
    result_o.error_code = ERR_NONE;
    case (cur.parser_state)
      ST_COMMENT: begin
        if (cur.match_index && in_byte_i == CH_SLASH) begin
          state_o.parser_state = ST_WS;
        end else if (!cur.match_index && in_byte_i == CH_STAR) begin
          state_o.match_index = 1'b1;
        end
      end
      ST_KEY: begin
        if (in_byte_i == CH_QUOTE) begin
          state_o.parser_state = ST_AFTER_KEY;
        end else if (in_byte_i == CH_LF) begin
          result_o.error_code = ERR_KEY_NEWLINE;
        end else begin
          result_o.event_kind = EV_KEY;
          result_o.out_byte   = in_byte_i;
        end
      end
      ST_AFTER_KEY: begin
        if (in_byte_i == CH_EQUAL) begin
          state_o.parser_state = ST_BEFORE_VAL;
        end else if (!is_ws) begin
          result_o.error_code = ERR_AFTER_KEY;
        end
      end
      ST_BEFORE_VAL: begin
        if (in_byte_i == CH_QUOTE) begin
          state_o.parser_state = ST_VAL;
        end else if (!is_ws) begin
          result_o.error_code = ERR_BEFORE_VALUE;
        end
      end
      ST_VAL: begin
        if (in_byte_i == CH_QUOTE) begin
          state_o.parser_state = ST_AFTER_VAL;
        end else if (in_byte_i == CH_LF) begin
          result_o.error_code = ERR_VAL_NEWLINE;
        end else begin
          result_o.event_kind = EV_VAL;
          result_o.out_byte   = in_byte_i;
        end
      end
      ST_AFTER_VAL: begin
        if (in_byte_i == CH_SEMI) begin
          state_o.parser_state = ST_WS;
          result_o.event_kind  = EV_DONE;
        end else if (!is_ws) begin
          result_o.error_code = ERR_AFTER_VALUE;
        end
      end
      default: begin
        // whitespace, and the unused code folds into it
        state_o.parser_state = ST_WS;
        if (cur.match_index) begin
          if (in_byte_i == CH_STAR) begin
            state_o.parser_state = ST_COMMENT;
          end else begin
            result_o.error_code = ERR_BAD_CHAR;
          end
        end else if (is_ws) begin
          state_o.parser_state = ST_WS;
        end else if (in_byte_i == CH_SLASH) begin
          state_o.match_index = 1'b1;
        end else if (in_byte_i == CH_QUOTE) begin
          state_o.parser_state = ST_KEY;
        end else begin
          result_o.error_code = ERR_BAD_CHAR;
        end
      end
    endcase
  end

endmodule

### src/key_value_strings_tokenizer.sv
`timescale 1ns / 1ps

// Byte-serial tokenizer for "key" = "value"; entries with block comments.
// Input channel: in_valid_i / in_stall_o carry one file byte per request,
// with first_byte_i set on the first byte of a file to restart the parser.
// Output channel: out_valid_o / out_stall_i carry exactly one result per
// input request: event kind (nothing, key byte, value byte, entry complete),
// the key or value byte, and an error code.
// The result is registered and shown in the cycle after the byte is taken.
// Throughput: one byte per cycle while the receiver does not stall; the
// parser state and the result register are both updated in the same
// cycle by one pass of the next-state logic. The next byte is taken
// while the output register is empty or is being emptied in the same
// cycle. When the receiver stalls, the result is held and the input
// is stalled until the result is taken; no result is dropped or repeated.
// Reset puts the parser in the whitespace state, clears the pending
// slash/star flag and empties the output register.
module key_value_strings_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       first_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_kind_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] error_code_o
);
  import kvst_pkg::*;

  kvst_state_t  state_q, state_d;
  kvst_result_t result_q, result_d;
  logic         out_valid_q;
  logic         in_accept;

  // Take a request whenever the output register is free this cycle
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  kvst_step u_step (
    .state_i      (state_q),
    .in_byte_i    (in_byte_i),
    .first_byte_i (first_byte_i),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // Advance parser state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.parser_state <= ST_WS;
      state_q.match_index  <= 1'b0;
      out_valid_q          <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register; hold it while stalled
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = result_q.event_kind;
  assign out_byte_o   = result_q.out_byte;
  assign error_code_o = result_q.error_code;

endmodule

### src/kvst_checker.sv
`timescale 1ns / 1ps

module kvst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] event_kind_o,
  input logic [7:0] out_byte_o,
  input logic [2:0] error_code_o
);
  import kvst_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(event_kind_o) && $stable(out_byte_o) && $stable(error_code_o))
    else $error("stalled result changed");

  // Every accepted byte yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted byte gave no result");

  // Input is stalled only by a stalled, occupied output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A key or value byte never carries an error
  a_event_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_KEY || event_kind_o == EV_VAL) |->
      error_code_o == ERR_NONE)
    else $error("data event with error code");

endmodule

bind key_value_strings_tokenizer kvst_checker u_kvst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .event_kind_o (event_kind_o),
  .out_byte_o   (out_byte_o),
  .error_code_o (error_code_o)
);
